// File: hdl/box_blur_3x3_rgba_macros.svh
`ifndef BOX_BLUR_3X3_RGBA_MACROS_SVH
`define BOX_BLUR_3X3_RGBA_MACROS_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define BBLUR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define BBLUR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bblur_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bblur_pkg;

  localparam int unsigned CFG_W   = 11;
  localparam int unsigned IDX_W   = 1;
  localparam int unsigned RGB_W   = 24;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned MIN_DIM = 3;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd800;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd600;
  localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hFF;

  // 2^15 / 9 rounded up; exact for sums up to 9 * 255
  localparam logic [SUM_W-1:0] DIV9_RECIP = 12'd3641;
  localparam int unsigned      DIV9_SHIFT = 15;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Per-item decisions taken at acceptance
  typedef struct packed {
    logic pre_res;   // result from the window before the shift (line start)
    logic post_res;  // result from the window after the shift
    logic eof;       // last result of the frame
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic zero_pix;  // row lies below the frame
  } pos_info_t;

  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [2*SUM_W-1:0] p;
    p = (2*SUM_W)'(s) * (2*SUM_W)'(DIV9_RECIP);
    return p[DIV9_SHIFT +: CH_W];
  endfunction

endpackage

`default_nettype wire

// File: hdl/bblur_pos.sv
`timescale 1ns / 1ps
`default_nettype none

module bblur_pos #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [bblur_pkg::CFG_W-1:0]       cfg_width_i,
  input  wire logic [bblur_pkg::CFG_W-1:0]       cfg_height_i,
  input  wire logic                              adv_i,
  output logic [$clog2(MAX_WIDTH)-1:0]           col_o,
  output bblur_pkg::pos_info_t                   info_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 4);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 2);
  localparam int unsigned DW0 = (WW > RW) ? WW : RW;
  localparam int unsigned DW  = ((DW0 > bblur_pkg::CFG_W) ? DW0 : bblur_pkg::CFG_W) + 1;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [DW-1:0] w_ext, h_ext, eff_w, eff_h;
  logic [DW-1:0] c1, r1, c_nxt, r_nxt;
  bblur_pkg::pos_info_t info;

  always_comb begin
    w_ext = DW'(cfg_width_i);
    h_ext = DW'(cfg_height_i);
    if (w_ext < DW'(bblur_pkg::MIN_DIM)) begin
      eff_w = DW'(bblur_pkg::MIN_DIM);
    end else if (w_ext > DW'(MAX_WIDTH)) begin
      eff_w = DW'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    if (h_ext < DW'(bblur_pkg::MIN_DIM)) begin
      eff_h = DW'(bblur_pkg::MIN_DIM);
    end else if (h_ext > DW'(MAX_HEIGHT)) begin
      eff_h = DW'(MAX_HEIGHT);
    end else begin
      eff_h = h_ext;
    end

    // wrap a column left beyond a narrowed line, restart past the frame
    c1 = DW'(col_q);
    r1 = DW'(row_q);
    if (c1 >= eff_w) begin
      c1 = '0;
      r1 = r1 + DW'(1);
    end
    if (r1 > eff_h + DW'(1)) begin
      c1 = '0;
      r1 = '0;
    end

    info.pre_res  = (c1 == '0) && (r1 >= DW'(2)) && (r1 < eff_h + DW'(2));
    info.post_res = (c1 != '0) && (r1 >= DW'(1)) && (r1 < eff_h + DW'(1));
    info.eof      = info.pre_res && (r1 == eff_h + DW'(1));
    info.top_ok   = info.pre_res ? (r1 >= DW'(3)) : (r1 >= DW'(2));
    info.bot_ok   = info.pre_res ? (r1 < eff_h + DW'(1)) : (r1 < eff_h);
    info.left_ok  = info.pre_res ? 1'b1 : (c1 >= DW'(2));
    info.zero_pix = (r1 >= eff_h);

    c_nxt = c1 + DW'(1);
    r_nxt = r1;
    if (c_nxt >= eff_w) begin
      c_nxt = '0;
      r_nxt = r1 + DW'(1);
    end
    if (info.eof) begin
      c_nxt = '0;
      r_nxt = '0;
    end
    col_d = CW'(c_nxt);
    row_d = RW'(r_nxt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (adv_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o  = CW'(c1);
  assign info_o = info;

endmodule

`default_nettype wire

// File: hdl/bblur_line_store.sv
`timescale 1ns / 1ps
`default_nettype none

module bblur_line_store #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]             rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0]        wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: hdl/bblur_window.sv
`timescale 1ns / 1ps
`default_nettype none

module bblur_window (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic [bblur_pkg::RGB_W-1:0]   top_i,
  input  wire logic [bblur_pkg::RGB_W-1:0]   mid_i,
  input  wire logic [bblur_pkg::RGB_W-1:0]   bot_i,
  input  wire bblur_pkg::pos_info_t          info_i,
  output logic [31:0]                        pixel_o
);

  logic [bblur_pkg::RGB_W-1:0] tap_q [3][3];
  logic [bblur_pkg::RGB_W-1:0] tap_d [3][3];
  logic [bblur_pkg::RGB_W-1:0] src   [3][3];
  logic [2:0] row_ok, col_ok;
  logic [bblur_pkg::SUM_W-1:0] rs, gs, bs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tap_d[i][0] = tap_q[i][1];
      tap_d[i][1] = tap_q[i][2];
    end
    tap_d[0][2] = top_i;
    tap_d[1][2] = mid_i;
    tap_d[2][2] = bot_i;
  end

  always_comb begin
    row_ok = {info_i.bot_ok, 1'b1, info_i.top_ok};
    col_ok = {info_i.post_res, 1'b1, info_i.left_ok};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        src[i][j] = info_i.pre_res ? tap_q[i][j] : tap_d[i][j];
      end
    end
    rs = '0;
    gs = '0;
    bs = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_ok[i] && col_ok[j]) begin
          rs = rs + bblur_pkg::SUM_W'(src[i][j][23:16]);
          gs = gs + bblur_pkg::SUM_W'(src[i][j][15:8]);
          bs = bs + bblur_pkg::SUM_W'(src[i][j][7:0]);
        end
      end
    end
    pixel_o = {bblur_pkg::div9(rs), bblur_pkg::div9(gs), bblur_pkg::div9(bs),
               bblur_pkg::ALPHA_OPAQUE};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          tap_q[i][j] <= '0;
        end
      end
    end else if (adv_i) begin
      tap_q <= tap_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/box_blur_3x3_rgba.sv
// 3x3 box blur over a raster stream of RGBA8888 pixels.
//
// Input stream: s_axis_tdata carries one pixel (red 31:24, green 23:16,
// blue 15:8, alpha ignored); s_axis_tuser marks a flush request whose pixel
// counts as zero. After width*height frame pixels, send width+1 flush
// requests to drain the last line. Output stream: m_axis_tdata is the blurred
// pixel with alpha 0xFF, m_axis_tlast flags the last pixel of the frame.
// Frame size comes from the cfg_* write port; write it only while idle.
//
// Throughput is one request per clock while the output is not stalled.
// A request passes through an input stage (line store read, position
// decode) and the window/average stage into the output register; a result
// leaves one line plus one pixel after its source.
// When the receiver stalls, the output register holds and the input stage
// fills, then s_axis_tready drops. Reset returns the frame position and
// window to zero; the line stores need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_3x3_rgba_macros.svh"

module box_blur_3x3_rgba #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [bblur_pkg::IDX_W-1:0]        cfg_addr_i,
  input  wire logic [bblur_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [31:0]                        s_axis_tdata,  // pixel_word
  input  wire logic                               s_axis_tuser,  // is_padding
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [31:0]                             m_axis_tdata,  // pixel_out
  output logic                                    m_axis_tlast   // end_of_frame
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RGB_W = bblur_pkg::RGB_W;

  logic [bblur_pkg::CFG_W-1:0] cfg_width_q, cfg_height_q;

  logic                  s_accept;
  logic [CW-1:0]         acc_col;
  bblur_pkg::pos_info_t  acc_info;

  logic                  b_valid_q;
  logic [CW-1:0]         b_col_q;
  logic [RGB_W-1:0]      b_pix_q;
  bblur_pkg::pos_info_t  b_info_q;
  logic                  b_fire;

  logic                  fwd_q;
  logic [2*RGB_W-1:0]    fwd_data_q;
  logic [2*RGB_W-1:0]    rd_data, rd_eff, wr_data;

  logic [31:0]           blur_pixel;
  logic                  out_valid_q, out_last_q;
  logic [31:0]           out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= bblur_pkg::RESET_WIDTH;
      cfg_height_q <= bblur_pkg::RESET_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (bblur_pkg::cfg_reg_e'(cfg_addr_i))
        bblur_pkg::REG_FRAME_WIDTH:  cfg_width_q  <= cfg_wdata_i;
        bblur_pkg::REG_FRAME_HEIGHT: cfg_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign b_fire        = b_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !b_valid_q || b_fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  bblur_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (cfg_width_q),
    .cfg_height_i (cfg_height_q),
    .adv_i        (s_accept),
    .col_o        (acc_col),
    .info_o       (acc_info)
  );

  // each entry holds {upper line, lower line} for one column
  bblur_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * RGB_W)
  ) u_lines (
    .clk_i     (clk_i),
    .rd_en_i   (s_accept),
    .rd_addr_i (acc_col),
    .rd_data_o (rd_data),
    .wr_en_i   (b_fire),
    .wr_addr_i (b_col_q),
    .wr_data_i (wr_data)
  );

  // forward a write that landed at the same edge as this column's read
  assign rd_eff  = fwd_q ? fwd_data_q : rd_data;
  assign wr_data = {rd_eff[RGB_W-1:0], b_pix_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (s_accept) begin
      b_valid_q <= 1'b1;
      fwd_q     <= b_fire && (b_col_q == acc_col);
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      b_col_q    <= acc_col;
      b_info_q   <= acc_info;
      b_pix_q    <= (s_axis_tuser || acc_info.zero_pix) ? '0 : s_axis_tdata[31:8];
      fwd_data_q <= wr_data;
    end
  end

  bblur_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (b_fire),
    .top_i   (rd_eff[2*RGB_W-1:RGB_W]),
    .mid_i   (rd_eff[RGB_W-1:0]),
    .bot_i   (b_pix_q),
    .info_i  (b_info_q),
    .pixel_o (blur_pixel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_fire && (b_info_q.pre_res || b_info_q.post_res)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && (b_info_q.pre_res || b_info_q.post_res)) begin
      out_data_q <= blur_pixel;
      out_last_q <= b_info_q.eof;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `BBLUR_ASSERT_IMP(a_fwd_needs_item, fwd_q, b_valid_q, "forward flag set with empty stage")
  `BBLUR_ASSERT_IMP(a_stall_blocks_input, b_valid_q && out_valid_q && !m_axis_tready, !s_axis_tready, "input taken while output stalled")
  `BBLUR_ASSERT_NXT(a_result_lands, b_fire && (b_info_q.pre_res || b_info_q.post_res), m_axis_tvalid, "result lost on its way out")

endmodule

`default_nettype wire
